>>> hw/rtl/ima_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_pkg
// Shared types and constants of the pair invariant-mass block.
// ----------------------------------------------------------------------------
package ima_pkg;

  localparam int ComponentBits = 16;
  localparam int SumBits       = ComponentBits + 1;
  localparam int SquareBits    = 2 * ComponentBits + 1;
  localparam int DiffBits      = 2 * ComponentBits + 3;
  localparam int RootBits      = ComponentBits + 2;
  localparam int RadBits       = 2 * RootBits;
  localparam int MassBits      = 17;

  localparam logic [MassBits-1:0] MassMax = '1;

  typedef enum logic [1:0] {
    KindReal = 2'd0,
    KindZero = 2'd1,
    KindImag = 2'd2
  } kind_e;

  typedef logic signed [ComponentBits-1:0] comp_t;

  typedef struct packed {
    comp_t energy_a;
    comp_t momx_a;
    comp_t momy_a;
    comp_t momz_a;
    comp_t energy_b;
    comp_t momx_b;
    comp_t momy_b;
    comp_t momz_b;
  } in_t;

  typedef struct packed {
    logic [MassBits-1:0] mass_magnitude;
    kind_e               interval_kind;
  } out_t;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/two_particle_invariant_mass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_particle_invariant_mass
// Invariant mass of the sum of two four-vectors.
// ----------------------------------------------------------------------------
// The block takes one pair of four-vectors per clock and returns one result
// per pair, fully pipelined: one stage for the component sums, one for the
// squares, one for E^2 and p^2, one for the compare and difference, one
// square-root cell per root bit (ComponentBits + 2 cells) and the output
// register. The whole pipeline holds while a result waits on a stalled
// output; otherwise a new pair is taken every cycle.
module two_particle_invariant_mass (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ima_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ima_pkg::out_t out_data_o
);

  localparam int Rw   = ima_pkg::RootBits;
  localparam int Aw   = ima_pkg::RadBits;
  localparam int Dw   = ima_pkg::DiffBits;
  localparam int Mw   = ima_pkg::MassBits;
  localparam int SatW = (Rw > Mw) ? Rw : Mw;

  logic                en;
  logic                out_valid_q;
  ima_pkg::out_t       out_data_q;
  logic [Dw-1:0]       diff;

  ima_pkg::lane_ctrl_t ctrl [Rw+1];
  logic [Aw-1:0]       rad  [Rw+1];
  logic [Rw-1:0]       rem  [Rw+1];
  logic [Rw-1:0]       root [Rw+1];

  logic [SatW-1:0]     root_w;
  logic [Mw-1:0]       mass_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  ima_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .ctrl_o     (ctrl[0]),
    .diff_o     (diff)
  );

  assign rad[0]  = Aw'(diff);
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < Rw; i++) begin : g_cell
    ima_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl[i]),
      .rad_i  (rad[i]),
      .rem_i  (rem[i]),
      .root_i (root[i]),
      .ctrl_o (ctrl[i+1]),
      .rad_o  (rad[i+1]),
      .rem_o  (rem[i+1]),
      .root_o (root[i+1])
    );
  end

  // saturate a root that outgrows the result field
  assign root_w = SatW'(root[Rw]);
  assign mass_d = (root_w > SatW'(ima_pkg::MassMax)) ? ima_pkg::MassMax : Mw'(root_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctrl[Rw].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.mass_magnitude <= mass_d;
      out_data_q.interval_kind  <= ctrl[Rw].kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/ima_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_front
// Sums the two four-vectors, squares the components, forms E^2 and p^2,
// classifies the interval and hands |E^2 - p^2| to the root chain.
// ----------------------------------------------------------------------------
module ima_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  ima_pkg::in_t                       in_data_i,
  output ima_pkg::lane_ctrl_t                ctrl_o,
  output logic [ima_pkg::DiffBits-1:0]       diff_o
);

  localparam int Sw = ima_pkg::SumBits;
  localparam int Qw = ima_pkg::SquareBits;
  localparam int Dw = ima_pkg::DiffBits;

  // stage 1: component sums
  logic                 s1_valid_q;
  logic signed [Sw-1:0] e_q, px_q, py_q, pz_q;
  // stage 2: squares
  logic                 s2_valid_q;
  logic [Qw-1:0]        esq_q, xsq_q, ysq_q, zsq_q;
  // stage 3: E^2 and p^2
  logic                 s3_valid_q;
  logic [Qw-1:0]        e2_q;
  logic [Dw-1:0]        p2_q;
  // stage 4: compare and magnitude of the difference
  ima_pkg::lane_ctrl_t  ctrl_q;
  logic [Dw-1:0]        diff_q;

  logic signed [2*Sw-1:0] esq_full, xsq_full, ysq_full, zsq_full;
  logic [Dw-1:0]          e2_ext;
  ima_pkg::kind_e         kind_d;

  assign esq_full = e_q * e_q;
  assign xsq_full = px_q * px_q;
  assign ysq_full = py_q * py_q;
  assign zsq_full = pz_q * pz_q;
  assign e2_ext   = Dw'(e2_q);

  always_comb begin
    if (e2_ext > p2_q) begin
      kind_d = ima_pkg::KindReal;
    end else if (e2_ext == p2_q) begin
      kind_d = ima_pkg::KindZero;
    end else begin
      kind_d = ima_pkg::KindImag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      ctrl_q     <= '{valid: 1'b0, kind: ima_pkg::KindZero};
    end else if (en_i) begin
      s1_valid_q   <= in_valid_i;
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      ctrl_q.valid <= s3_valid_q;
      ctrl_q.kind  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= Sw'(in_data_i.energy_a) + Sw'(in_data_i.energy_b);
      px_q   <= Sw'(in_data_i.momx_a) + Sw'(in_data_i.momx_b);
      py_q   <= Sw'(in_data_i.momy_a) + Sw'(in_data_i.momy_b);
      pz_q   <= Sw'(in_data_i.momz_a) + Sw'(in_data_i.momz_b);
      // a square of a sum never exceeds 2^(2*ComponentBits)
      esq_q  <= esq_full[Qw-1:0];
      xsq_q  <= xsq_full[Qw-1:0];
      ysq_q  <= ysq_full[Qw-1:0];
      zsq_q  <= zsq_full[Qw-1:0];
      e2_q   <= esq_q;
      p2_q   <= Dw'(xsq_q) + Dw'(ysq_q) + Dw'(zsq_q);
      diff_q <= (e2_ext >= p2_q) ? (e2_ext - p2_q) : (p2_q - e2_ext);
    end
  end

  assign ctrl_o = ctrl_q;
  assign diff_o = diff_q;

endmodule

>>> hw/rtl/ima_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_sqrt_cell
// One restoring square-root cell: takes two radicand bits, settles one root
// bit and passes radicand, remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module ima_sqrt_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  ima_pkg::lane_ctrl_t               ctrl_i,
  input  logic [ima_pkg::RadBits-1:0]       rad_i,
  input  logic [ima_pkg::RootBits-1:0]      rem_i,
  input  logic [ima_pkg::RootBits-1:0]      root_i,
  output ima_pkg::lane_ctrl_t               ctrl_o,
  output logic [ima_pkg::RadBits-1:0]       rad_o,
  output logic [ima_pkg::RootBits-1:0]      rem_o,
  output logic [ima_pkg::RootBits-1:0]      root_o
);

  localparam int Rw = ima_pkg::RootBits;
  localparam int Aw = ima_pkg::RadBits;

  ima_pkg::lane_ctrl_t ctrl_q;
  logic [Aw-1:0]       rad_q;
  logic [Rw-1:0]       rem_q, root_q;

  logic [Rw+1:0] rem_sh, trial, rem_dif, rem_d;
  logic          take;

  // remainder stays below 2^Rw up to the last cell, whose remainder is dead
  assign rem_sh  = {rem_i, rad_i[Aw-1 -: 2]};
  assign trial   = {root_i, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_dif = rem_sh - trial;
  assign rem_d   = take ? rem_dif : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{valid: 1'b0, kind: ima_pkg::KindZero};
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[Aw-3:0], 2'b00};
      rem_q  <= rem_d[Rw-1:0];
      root_q <= {root_i[Rw-2:0], take};
    end
  end

  assign ctrl_o = ctrl_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/ima_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_checker
// Port-level checks of the invariant-mass block, bound to its top level.
// ----------------------------------------------------------------------------
module ima_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ima_pkg::out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // the pipeline freezes while the output is stalled
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // with nothing pending at the output the block always takes a beat
  a_free_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with an empty output");

  // zero-mass results carry a zero magnitude
  a_zero_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.interval_kind == ima_pkg::KindZero
      |-> out_data_o.mass_magnitude == '0)
    else $error("zero-mass result with non-zero magnitude");

  // only the three defined kind codes appear
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.interval_kind == ima_pkg::KindReal ||
                     out_data_o.interval_kind == ima_pkg::KindZero ||
                     out_data_o.interval_kind == ima_pkg::KindImag))
    else $error("undefined interval kind");

endmodule

bind two_particle_invariant_mass ima_checker u_ima_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
